[rtl/kvs_pkg.sv]
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared types and constants for the key velocity scanner: phase codes, the
// per-key record kept in the key memory and the reciprocal divider interface.
// ----------------------------------------------------------------------------
package kvs_pkg;

   // default keyboard geometry
   localparam int OCTAVES_DEF         = 8;
   localparam int KEYS_PER_OCTAVE_DEF = 16;

   // field widths
   localparam int OCT_W   = 3;
   localparam int TONE_W  = 4;
   localparam int TIME_W  = 32;
   localparam int TRAV_W  = 16;
   localparam int VOL_W   = 16;

   // divider operands: numerator and divisor reach 2^16
   localparam int DIV_W   = 17;

   localparam logic [VOL_W-1:0]  Q15_ONE    = 16'h8000;
   localparam logic [VOL_W-1:0]  Q15_ZERO   = 16'h0000;
   localparam logic [TRAV_W-1:0] TRAVEL_MAX = 16'hFFFF;

   // per-key contact phase
   typedef enum logic [1:0] {
      PH_RELEASED = 2'd0,
      PH_HALF     = 2'd1,
      PH_FULL     = 2'd2
   } phase_type;

   // one key record in memory
   typedef struct packed {
      phase_type             phase;
      logic [TIME_W-1:0]     start_time;
      logic [TRAV_W-1:0]     travel;
      logic [VOL_W-1:0]      volume;
   } rec_type;

   // divider request and response
   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   num;
      logic [DIV_W-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VOL_W-1:0]   quot;
   } div_rsp_type;

endpackage

[rtl/kvs_recip_div.sv]
// ----------------------------------------------------------------------------
// kvs_recip_div
// Restoring radix-2 divider, one quotient bit per cycle. Gives the rounded
// Q1.15 reciprocal from a prepared numerator and divisor.
// ----------------------------------------------------------------------------
module kvs_recip_div (
   input  logic                 clock,
   input  logic                 reset,
   input  kvs_pkg::div_req_type div_req,
   output kvs_pkg::div_rsp_type div_rsp
);

   localparam int DW    = kvs_pkg::DIV_W;
   localparam int CNT_W = $clog2(DW + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DW:0]        rem_ff, rem_in;
   logic [DW-1:0]      shf_ff, shf_in;
   logic [DW-1:0]      den_ff, den_in;
   logic               done_ff, done_in;
   logic [DW:0]        trial;
   logic               qbit;
   logic               last;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff[DW-1:0], shf_ff[DW-1]};
      qbit    = (trial >= {1'b0, den_ff});
      last    = (cnt_ff == CNT_W'(DW - 1));
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         shf_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in  = qbit ? (trial - {1'b0, den_ff}) : trial;
         shf_in  = {shf_ff[DW-2:0], qbit};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      den_ff <= den_in;
   end

   // quotient never exceeds 1.0 in Q1.15
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = shf_ff[kvs_pkg::VOL_W-1:0];

endmodule

[rtl/key_velocity_scanner.sv]
// ----------------------------------------------------------------------------
// key_velocity_scanner
// Per-key scanner for a keyboard with two contacts per key.
// ----------------------------------------------------------------------------
// Each accepted sample gives one result for its key. Per-key records (phase,
// start time, travel, volume) live in one synchronous memory with per-entry
// valid bits, so reset takes effect at once with no clearing pass. One sample
// is processed at a time as a read, update and write back, with a pass through
// the bit-serial reciprocal divider when a fully pressed key needs its volume
// recomputed. The next sample can be taken in the same cycle as the result is
// offered, and a new sample is taken while the previous result still waits on
// rsp_stall.
// sense_mode 0 makes volume follow the lower contact; 1 runs the two-contact
// velocity machine with volume 1/(1+travel ms) in unsigned Q1.15.
module key_velocity_scanner #(
   parameter int OCTAVES         = kvs_pkg::OCTAVES_DEF,
   parameter int KEYS_PER_OCTAVE = kvs_pkg::KEYS_PER_OCTAVE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kvs_pkg::OCT_W-1:0]     req_octave_index,
   input  logic [kvs_pkg::TONE_W-1:0]    req_tone_index,
   input  logic                          req_upper_contact,
   input  logic                          req_lower_contact,
   input  logic [kvs_pkg::TIME_W-1:0]    req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kvs_pkg::OCT_W-1:0]     rsp_out_octave,
   output logic [kvs_pkg::TONE_W-1:0]    rsp_out_tone,
   output logic [kvs_pkg::VOL_W-1:0]     rsp_volume_q15,
   output logic [1:0]                    rsp_key_phase
);

   localparam int NKEYS  = OCTAVES * KEYS_PER_OCTAVE;
   localparam int ADDR_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;
   localparam int DW     = kvs_pkg::DIV_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EXEC = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic                          mode_ff;
   logic [NKEYS-1:0]              valid_ff, valid_in;
   logic [kvs_pkg::OCT_W-1:0]     oct_ff, oct_in;
   logic [kvs_pkg::TONE_W-1:0]    tone_ff, tone_in;
   logic                          upper_ff, upper_in;
   logic                          lower_ff, lower_in;
   logic [kvs_pkg::TIME_W-1:0]    now_ff, now_in;
   logic                          range_ff, range_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   kvs_pkg::rec_type              rd_rec_ff;
   kvs_pkg::rec_type              new_rec_ff, new_rec_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [kvs_pkg::OCT_W-1:0]     rsp_oct_ff, rsp_oct_in;
   logic [kvs_pkg::TONE_W-1:0]    rsp_tone_ff, rsp_tone_in;
   logic [kvs_pkg::VOL_W-1:0]     rsp_vol_ff, rsp_vol_in;
   logic [1:0]                    rsp_phase_ff, rsp_phase_in;

   kvs_pkg::rec_type              mem [NKEYS];
   kvs_pkg::rec_type              cur_rec;
   kvs_pkg::rec_type              upd_rec;
   logic                          need_div;
   logic [kvs_pkg::TIME_W-1:0]    elapsed;
   logic [kvs_pkg::TRAV_W-1:0]    travel_sat;
   logic [DW-1:0]                 div_den;
   logic                          req_xfer;
   logic                          rsp_xfer;
   logic                          slot_free;
   logic                          mem_we;
   kvs_pkg::div_req_type          div_req;
   kvs_pkg::div_rsp_type          div_rsp;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign mem_we    = (state_ff == S_DONE) && slot_free && range_ff;

   // record as read, unwritten entries read as reset value
   assign cur_rec = valid_ff[addr_ff] ? rd_rec_ff : '0;

   // travel since upper closure, saturated
   assign elapsed    = now_ff - cur_rec.start_time;
   assign travel_sat = (|elapsed[kvs_pkg::TIME_W-1:kvs_pkg::TRAV_W]) ?
                       kvs_pkg::TRAVEL_MAX : elapsed[kvs_pkg::TRAV_W-1:0];

   // reciprocal operands: d = 1 + travel, n = 1.0 + d/2
   assign div_den       = {1'b0, cur_rec.travel} + DW'(1);
   assign div_req.start = (state_ff == S_EXEC) && need_div;
   assign div_req.den   = div_den;
   assign div_req.num   = {1'b0, kvs_pkg::Q15_ONE} + (div_den >> 1);

   // per-key record update
   always_comb begin
      upd_rec  = cur_rec;
      need_div = 1'b0;
      if (!mode_ff) begin
         upd_rec.volume = lower_ff ? kvs_pkg::Q15_ONE : kvs_pkg::Q15_ZERO;
      end else begin
         unique case (cur_rec.phase)
            kvs_pkg::PH_RELEASED: begin
               if (upper_ff) begin
                  upd_rec.start_time = now_ff;
                  upd_rec.phase      = kvs_pkg::PH_HALF;
               end
            end
            kvs_pkg::PH_HALF: begin
               if (!upper_ff && !lower_ff) begin
                  upd_rec.phase = kvs_pkg::PH_RELEASED;
               end else if (upper_ff && lower_ff) begin
                  upd_rec.travel = travel_sat;
                  upd_rec.phase  = kvs_pkg::PH_FULL;
               end
            end
            kvs_pkg::PH_FULL: begin
               if (!upper_ff && !lower_ff) begin
                  upd_rec.volume = kvs_pkg::Q15_ZERO;
                  upd_rec.phase  = kvs_pkg::PH_RELEASED;
               end else if (upper_ff && !lower_ff) begin
                  upd_rec.volume = kvs_pkg::Q15_ZERO;
                  upd_rec.phase  = kvs_pkg::PH_HALF;
               end else if (upper_ff && lower_ff) begin
                  need_div = 1'b1;
               end
            end
            default: begin
               upd_rec.phase = kvs_pkg::PH_RELEASED;
            end
         endcase
      end
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      oct_in       = oct_ff;
      tone_in      = tone_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      now_in       = now_ff;
      range_in     = range_ff;
      addr_in      = addr_ff;
      new_rec_in   = new_rec_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_oct_in   = rsp_oct_ff;
      rsp_tone_in  = rsp_tone_ff;
      rsp_vol_in   = rsp_vol_ff;
      rsp_phase_in = rsp_phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               oct_in   = req_octave_index;
               tone_in  = req_tone_index;
               upper_in = req_upper_contact;
               lower_in = req_lower_contact;
               now_in   = req_now_ms;
               range_in = (32'(req_octave_index) < OCTAVES) &&
                          (32'(req_tone_index) < KEYS_PER_OCTAVE);
               addr_in  = ADDR_W'(32'(req_octave_index) * KEYS_PER_OCTAVE +
                                  32'(req_tone_index));
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            new_rec_in = upd_rec;
            state_in   = need_div ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               new_rec_in.volume = div_rsp.quot;
               state_in          = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               if (range_ff) begin
                  valid_in[addr_ff] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_oct_in   = oct_ff;
               rsp_tone_in  = tone_ff;
               rsp_vol_in   = range_ff ? new_rec_ff.volume : kvs_pkg::Q15_ZERO;
               rsp_phase_in = range_ff ? new_rec_ff.phase : kvs_pkg::PH_RELEASED;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      oct_ff       <= oct_in;
      tone_ff      <= tone_in;
      upper_ff     <= upper_in;
      lower_ff     <= lower_in;
      now_ff       <= now_in;
      range_ff     <= range_in;
      addr_ff      <= addr_in;
      new_rec_ff   <= new_rec_in;
      rsp_oct_ff   <= rsp_oct_in;
      rsp_tone_ff  <= rsp_tone_in;
      rsp_vol_ff   <= rsp_vol_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   // key record memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= new_rec_ff;
      end
      if (state_ff == S_READ) begin
         rd_rec_ff <= mem[addr_ff];
      end
   end

   kvs_recip_div u_recip_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_octave = rsp_oct_ff;
   assign rsp_out_tone   = rsp_tone_ff;
   assign rsp_volume_q15 = rsp_vol_ff;
   assign rsp_key_phase  = rsp_phase_ff;

endmodule

[rtl/kvs_checker.sv]
// ----------------------------------------------------------------------------
// kvs_checker
// Port-level checks for the key velocity scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kvs_checker #(
   parameter int OCTAVES         = kvs_pkg::OCTAVES_DEF,
   parameter int KEYS_PER_OCTAVE = kvs_pkg::KEYS_PER_OCTAVE_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [kvs_pkg::OCT_W-1:0]     rsp_out_octave,
   input logic [kvs_pkg::TONE_W-1:0]    rsp_out_tone,
   input logic [kvs_pkg::VOL_W-1:0]     rsp_volume_q15,
   input logic [1:0]                    rsp_key_phase
);

   // no result is offered right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_octave) &&
         $stable(rsp_out_tone) && $stable(rsp_volume_q15) && $stable(rsp_key_phase))
      else $error("stalled result changed");

   // volume never exceeds 1.0
   a_vol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_volume_q15 <= kvs_pkg::Q15_ONE)
      else $error("volume above full scale");

   // keys outside the keyboard report silence and released
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((32'(rsp_out_octave) >= OCTAVES) ||
                    (32'(rsp_out_tone) >= KEYS_PER_OCTAVE))
      |-> (rsp_volume_q15 == kvs_pkg::Q15_ZERO) && (rsp_key_phase == kvs_pkg::PH_RELEASED))
      else $error("out-of-range key has state");

endmodule

bind key_velocity_scanner kvs_checker #(
   .OCTAVES         (OCTAVES),
   .KEYS_PER_OCTAVE (KEYS_PER_OCTAVE)
) u_kvs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_octave (rsp_out_octave),
   .rsp_out_tone   (rsp_out_tone),
   .rsp_volume_q15 (rsp_volume_q15),
   .rsp_key_phase  (rsp_key_phase)
);

[tb/kvs_sample_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kvs_sample_checker
// Watches the sample and result channels of the key velocity scanner, keeps
// its own per-key records and sense mode, predicts the result of every sample
// transfer and compares each result transfer, field by field, with the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module kvs_sample_checker
   import kvs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [OCT_W-1:0]     req_octave_index,
   input  logic [TONE_W-1:0]    req_tone_index,
   input  logic                 req_upper_contact,
   input  logic                 req_lower_contact,
   input  logic [TIME_W-1:0]    req_now_ms,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [OCT_W-1:0]     rsp_out_octave,
   input  logic [TONE_W-1:0]    rsp_out_tone,
   input  logic [VOL_W-1:0]     rsp_volume_q15,
   input  logic [1:0]           rsp_key_phase,
   output int                   fail_count,
   output int                   pending_results
);

   localparam int KEY_COUNT = OCTAVES_DEF * KEYS_PER_OCTAVE_DEF;

   // one predicted result
   typedef struct packed {
      logic [OCT_W-1:0]  octave;
      logic [TONE_W-1:0] tone;
      logic [VOL_W-1:0]  volume;
      logic [1:0]        phase;
   } key_result_type;

   // predicted per-key records and sense mode
   logic              velocity_mode;
   phase_type         key_phase_mem   [KEY_COUNT];
   logic [TIME_W-1:0] press_start_mem [KEY_COUNT];
   logic [TRAV_W-1:0] travel_mem      [KEY_COUNT];
   logic [VOL_W-1:0]  volume_mem      [KEY_COUNT];
   key_result_type    expected_results [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   // prints one line and counts the failure
   task automatic report_failure(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // 1/(1+travel) in Q1.15, rounded half up
   function automatic logic [VOL_W-1:0] velocity_volume(input logic [TRAV_W-1:0] travel);
      logic [31:0] divisor;
      logic [31:0] quotient;
      divisor  = 32'd1 + 32'(travel);
      quotient = (32'd32768 + (divisor >> 1)) / divisor;
      return quotient[VOL_W-1:0];
   endfunction

   // updates the key record for one sample and returns its result
   function automatic key_result_type scan_key(input logic [OCT_W-1:0] oct,
         input logic [TONE_W-1:0] tone, input logic up, input logic lo,
         input logic [TIME_W-1:0] now);
      key_result_type res;
      int             k;
      logic [31:0]    elapsed;
      res.octave = oct;
      res.tone   = tone;
      res.volume = Q15_ZERO;
      res.phase  = PH_RELEASED;
      if (oct >= OCTAVES_DEF || tone >= KEYS_PER_OCTAVE_DEF)
         return res;
      k = oct * KEYS_PER_OCTAVE_DEF + tone;
      if (!velocity_mode) begin
         volume_mem[k] = lo ? Q15_ONE : Q15_ZERO;
      end else begin
         case (key_phase_mem[k])
            PH_RELEASED: begin
               if (up) begin
                  press_start_mem[k] = now;
                  key_phase_mem[k]   = PH_HALF;
               end
            end
            PH_HALF: begin
               if (!up && !lo) begin
                  key_phase_mem[k] = PH_RELEASED;
               end else if (up && lo) begin
                  // travel wraps at 32 bits, then saturates
                  elapsed       = now - press_start_mem[k];
                  travel_mem[k] = (elapsed > 32'(TRAVEL_MAX)) ? TRAVEL_MAX
                                                              : elapsed[TRAV_W-1:0];
                  key_phase_mem[k] = PH_FULL;
               end
            end
            PH_FULL: begin
               if (!up && !lo) begin
                  volume_mem[k]    = Q15_ZERO;
                  key_phase_mem[k] = PH_RELEASED;
               end else if (up && !lo) begin
                  volume_mem[k]    = Q15_ZERO;
                  key_phase_mem[k] = PH_HALF;
               end else if (up && lo) begin
                  volume_mem[k] = velocity_volume(travel_mem[k]);
               end
            end
            default: key_phase_mem[k] = PH_RELEASED;
         endcase
      end
      res.volume = volume_mem[k];
      res.phase  = key_phase_mem[k];
      return res;
   endfunction

   // compare result transfers, predict sample transfers, track the mode
   always @(posedge clock) begin
      key_result_type want;
      if (reset) begin
         velocity_mode = 1'b0;
         for (int i = 0; i < KEY_COUNT; i++) begin
            key_phase_mem[i]   = PH_RELEASED;
            press_start_mem[i] = '0;
            travel_mem[i]      = '0;
            volume_mem[i]      = Q15_ZERO;
         end
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_failure($sformatf("result for key %0d/%0d with none expected",
                                        rsp_out_octave, rsp_out_tone));
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_octave !== want.octave)
                  report_failure($sformatf("octave got %0d expected %0d",
                                           rsp_out_octave, want.octave));
               if (rsp_out_tone !== want.tone)
                  report_failure($sformatf("tone got %0d expected %0d",
                                           rsp_out_tone, want.tone));
               if (rsp_volume_q15 !== want.volume)
                  report_failure($sformatf("key %0d/%0d volume got %0d expected %0d",
                                           want.octave, want.tone, rsp_volume_q15,
                                           want.volume));
               if (rsp_key_phase !== want.phase)
                  report_failure($sformatf("key %0d/%0d phase got %0d expected %0d",
                                           want.octave, want.tone, rsp_key_phase,
                                           want.phase));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(scan_key(req_octave_index, req_tone_index,
                                                req_upper_contact, req_lower_contact,
                                                req_now_ms));
         if (csr_wr_en)
            velocity_mode = csr_wr_data;
      end
      pending_results <= expected_results.size();
   end

endmodule

[tb/tb_key_velocity_scanner.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_velocity_scanner
// Drives scan samples into the key velocity scanner in both sense modes:
// directed contact and timing corner cases, then random keystrokes with noise,
// under random idling on both channels and one long result hold-off. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_key_velocity_scanner;
   import kvs_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT     = 300;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic              csr_wr_data;
   logic              req_valid;
   logic              req_stall;
   logic [OCT_W-1:0]  req_octave_index;
   logic [TONE_W-1:0] req_tone_index;
   logic              req_upper_contact;
   logic              req_lower_contact;
   logic [TIME_W-1:0] req_now_ms;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [OCT_W-1:0]  rsp_out_octave;
   logic [TONE_W-1:0] rsp_out_tone;
   logic [VOL_W-1:0]  rsp_volume_q15;
   logic [1:0]        rsp_key_phase;

   int   fail_count;
   int   pending_results;
   int   items_sent = 0;
   logic calm;

   // stretch with no idling on either side
   assign calm = (items_sent >= 650) && (items_sent < 800);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   key_velocity_scanner dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_octave_index  (req_octave_index),
      .req_tone_index    (req_tone_index),
      .req_upper_contact (req_upper_contact),
      .req_lower_contact (req_lower_contact),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_octave    (rsp_out_octave),
      .rsp_out_tone      (rsp_out_tone),
      .rsp_volume_q15    (rsp_volume_q15),
      .rsp_key_phase     (rsp_key_phase)
   );

   kvs_sample_checker sample_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_octave_index  (req_octave_index),
      .req_tone_index    (req_tone_index),
      .req_upper_contact (req_upper_contact),
      .req_lower_contact (req_lower_contact),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_octave    (rsp_out_octave),
      .rsp_out_tone      (rsp_out_tone),
      .rsp_volume_q15    (rsp_volume_q15),
      .rsp_key_phase     (rsp_key_phase),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // offers one sample after a random gap and holds it until the transfer
   task automatic send_sample(input logic [OCT_W-1:0] oct, input logic [TONE_W-1:0] tone,
         input logic up, input logic lo, input logic [TIME_W-1:0] now);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_octave_index  <= oct;
      req_tone_index    <= tone;
      req_upper_contact <= up;
      req_lower_contact <= lo;
      req_now_ms        <= now;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   // stops offering and waits until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   task automatic write_sense_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // release, upper closure, lower closure after travel_ms, hold, may let go
   task automatic play_keystroke(input logic [OCT_W-1:0] oct, input logic [TONE_W-1:0] tone,
         input logic [TIME_W-1:0] t_start, input logic [TIME_W-1:0] travel_ms,
         input int holds);
      logic [TIME_W-1:0] t;
      t = t_start;
      send_sample(oct, tone, 1'b0, 1'b0, t - $urandom_range(50));
      send_sample(oct, tone, 1'b1, 1'b0, t);
      // half pressed: upper held, or lower bounce without upper
      if ($urandom_range(2) == 0)
         send_sample(oct, tone, 1'b1, 1'b0, t + (travel_ms >> 1));
      if ($urandom_range(3) == 0)
         send_sample(oct, tone, 1'b0, 1'b1, t + (travel_ms >> 1));
      t = t_start + travel_ms;
      send_sample(oct, tone, 1'b1, 1'b1, t);
      // held down, with occasional upper contact dropout
      repeat (holds) begin
         t = t + $urandom_range(30);
         if ($urandom_range(4) == 0)
            send_sample(oct, tone, 1'b0, 1'b1, t);
         else
            send_sample(oct, tone, 1'b1, 1'b1, t);
      end
      case ($urandom_range(3))
         0: send_sample(oct, tone, 1'b0, 1'b0, t + 1);
         1: begin
            send_sample(oct, tone, 1'b1, 1'b0, t + 1);
            send_sample(oct, tone, 1'b0, 1'b0, t + 2);
         end
         2: send_sample(oct, tone, 1'b1, 1'b0, t + 1);
         default: ;
      endcase
   endtask

   function automatic logic [TIME_W-1:0] pick_travel();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'(TRAVEL_MAX);
         2: return 32'd65536 + $urandom_range(1000000);
         3: return $urandom();
         default: return $urandom_range(400);
      endcase
   endfunction

   // mostly keystrokes with random content, some stray samples
   task automatic velocity_traffic(input int target);
      logic [TIME_W-1:0] t_start;
      while (items_sent < target) begin
         if ($urandom_range(4) == 0) begin
            send_sample(OCT_W'($urandom_range(7)), TONE_W'($urandom_range(15)),
                        1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
         end else begin
            t_start = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(300)
                                               : $urandom();
            play_keystroke(OCT_W'($urandom_range(7)), TONE_W'($urandom_range(15)),
                           t_start, pick_travel(), int'($urandom_range(1, 4)));
         end
      end
   endtask

   task automatic contact_traffic(input int target);
      while (items_sent < target)
         send_sample(OCT_W'($urandom_range(7)), TONE_W'($urandom_range(15)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
   endtask

   // result side: random stall, one long hold-off to fill the block
   initial begin : result_sink
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_OFF_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 32);
         end
      end
   end

   // ends the run when no transfer happens for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("key_velocity_scanner verification failed");
      $finish;
   end

   initial begin : stimulus
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= 1'b0;
      req_valid         <= 1'b0;
      req_octave_index  <= '0;
      req_tone_index    <= '0;
      req_upper_contact <= 1'b0;
      req_lower_contact <= 1'b0;
      req_now_ms        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_sense_mode(1'b0);

      // lower contact mode at the key and time extremes
      send_sample(3'd0, 4'd0, 1'b0, 1'b1, 32'd0);
      send_sample(3'd7, 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_sample(3'd3, 4'd9, 1'b1, 1'b0, 32'h5555_AAAA);
      send_sample(3'd7, 4'd15, 1'b0, 1'b0, 32'hAAAA_5555);
      drain_results();
      write_sense_mode(1'b1);

      // lower without upper on a released key
      send_sample(3'd5, 4'd2, 1'b0, 1'b1, 32'd100);
      // zero travel gives full scale
      play_keystroke(3'd0, 4'd0, 32'd1000, 32'd0, 1);
      // largest travel below saturation gives one lsb
      play_keystroke(3'd7, 4'd15, 32'h0001_0000, 32'(TRAVEL_MAX), 1);
      // travel above the limit saturates
      play_keystroke(3'd2, 4'd5, 32'd50, 32'd70000, 1);
      // timestamp wraps between the two closures
      play_keystroke(3'd4, 4'd11, 32'hFFFF_FFF0, 32'h40, 1);

      velocity_traffic(600);
      drain_results();
      write_sense_mode(1'b0);
      contact_traffic(820);
      drain_results();
      write_sense_mode(1'b1);
      velocity_traffic(1130);
      drain_results();

      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("key_velocity_scanner verification clean");
      else
         $display("key_velocity_scanner verification failed");
      $finish;
   end

endmodule
